### hw/rtl/quadratic_root_solver_assert.svh
// ---------------------------------------------------------------------------
// quadratic root solver assertion macros
// shared property templates for the port checker
// ---------------------------------------------------------------------------
`ifndef QUADRATIC_ROOT_SOLVER_ASSERT_SVH
`define QUADRATIC_ROOT_SOLVER_ASSERT_SVH

// condition holds at every edge out of reset
`define QRS_CHECK(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("qrs check failed");

// antecedent implies consequent in the same cycle
`define QRS_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("qrs implication failed");

`endif

### hw/rtl/qrs_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// qrs_pkg
// types and fixed widths shared by the quadratic root solver
// ---------------------------------------------------------------------------
package qrs_pkg;

  typedef enum logic [1:0] {
    CLS_NONE = 2'd0,
    CLS_ONE  = 2'd1,
    CLS_TWO  = 2'd2,
    CLS_ALL  = 2'd3
  } root_class_t;

  localparam int COEF_W    = 32;
  localparam int DELTA_W   = 66;
  localparam int SQ_STEPS  = 34;
  localparam int RAD_W     = 2 * SQ_STEPS;
  localparam int ROOT_W    = SQ_STEPS;
  localparam int SQ_REM_W  = ROOT_W + 3;
  localparam int NUM_W     = 34;
  localparam int DEN_W     = 33;

  typedef struct packed {
    root_class_t        cls;
    logic [COEF_W-1:0]  a;
    logic [COEF_W-1:0]  b;
    logic [COEF_W-1:0]  c;
  } coef_side_t;

endpackage

### hw/rtl/qrs_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// qrs_front
// coefficient capture, products, discriminant and root class
// ---------------------------------------------------------------------------
module qrs_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic signed [qrs_pkg::COEF_W-1:0]   in_a,
  input  logic signed [qrs_pkg::COEF_W-1:0]   in_b,
  input  logic signed [qrs_pkg::COEF_W-1:0]   in_c,
  output logic                                out_valid,
  output logic [qrs_pkg::RAD_W-1:0]           out_rad,
  output qrs_pkg::coef_side_t                 out_side
);

  logic                              v1_r, v2_r, v3_r;
  logic signed [qrs_pkg::COEF_W-1:0] a1_r, b1_r, c1_r, a2_r, b2_r, c2_r;
  logic [63:0]                       bb_r, bb_nxt;
  logic signed [63:0]                ac_r, ac_nxt;
  logic [31:0]                       bm;
  logic signed [66:0]                dl;
  qrs_pkg::root_class_t              cls;
  logic [qrs_pkg::RAD_W-1:0]         rad_r, rad_nxt;
  qrs_pkg::coef_side_t               side_r;

  assign bm     = b1_r[31] ? (32'd0 - b1_r) : b1_r;
  assign bb_nxt = bm * bm;
  assign ac_nxt = a1_r * c1_r;

  assign dl = $signed({3'b000, bb_r}) - ($signed({{3{ac_r[63]}}, ac_r}) <<< 2);

  always_comb begin
    if (a2_r == '0) begin
      if (b2_r == '0) begin
        cls = (c2_r == '0) ? qrs_pkg::CLS_ALL : qrs_pkg::CLS_NONE;
      end else begin
        cls = qrs_pkg::CLS_ONE;
      end
    end else if (dl[66]) begin
      cls = qrs_pkg::CLS_NONE;
    end else if (dl == '0) begin
      cls = qrs_pkg::CLS_ONE;
    end else begin
      cls = qrs_pkg::CLS_TWO;
    end
    rad_nxt = (cls == qrs_pkg::CLS_TWO) ? {2'b00, dl[qrs_pkg::DELTA_W-1:0]} : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    a1_r <= in_a;
    b1_r <= in_b;
    c1_r <= in_c;
    a2_r <= a1_r;
    b2_r <= b1_r;
    c2_r <= c1_r;
    bb_r <= bb_nxt;
    ac_r <= ac_nxt;
    rad_r <= rad_nxt;
    side_r.cls <= cls;
    side_r.a <= a2_r;
    side_r.b <= b2_r;
    side_r.c <= c2_r;
  end

  assign out_valid = v3_r;
  assign out_rad   = rad_r;
  assign out_side  = side_r;

endmodule

### hw/rtl/qrs_sqrt_cell.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// qrs_sqrt_cell
// one digit step of the integer square root, two radicand bits per cell
// ---------------------------------------------------------------------------
module qrs_sqrt_cell #(
  parameter int SIDE_W = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic [qrs_pkg::RAD_W-1:0]         in_rad,
  input  logic [qrs_pkg::SQ_REM_W-1:0]      in_rem,
  input  logic [qrs_pkg::ROOT_W-1:0]        in_root,
  input  logic [SIDE_W-1:0]                 in_side,
  output logic                              out_valid,
  output logic [qrs_pkg::RAD_W-1:0]         out_rad,
  output logic [qrs_pkg::SQ_REM_W-1:0]      out_rem,
  output logic [qrs_pkg::ROOT_W-1:0]        out_root,
  output logic [SIDE_W-1:0]                 out_side
);

  logic [qrs_pkg::SQ_REM_W-1:0] rem_sh, trial, rem_nxt, rem_r;
  logic [qrs_pkg::ROOT_W-1:0]   root_nxt, root_r;
  logic [qrs_pkg::RAD_W-1:0]    rad_nxt, rad_r;
  logic [SIDE_W-1:0]            side_r;
  logic                         valid_r, ge;

  assign rem_sh   = {in_rem[qrs_pkg::SQ_REM_W-3:0], in_rad[qrs_pkg::RAD_W-1 -: 2]};
  assign trial    = {1'b0, in_root, 2'b01};
  assign ge       = rem_sh >= trial;
  assign rem_nxt  = ge ? (rem_sh - trial) : rem_sh;
  assign root_nxt = {in_root[qrs_pkg::ROOT_W-2:0], ge};
  assign rad_nxt  = {in_rad[qrs_pkg::RAD_W-3:0], 2'b00};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
    rad_r  <= rad_nxt;
    side_r <= in_side;
  end

  assign out_valid = valid_r;
  assign out_rad   = rad_r;
  assign out_rem   = rem_r;
  assign out_root  = root_r;
  assign out_side  = side_r;

endmodule

### hw/rtl/qrs_div_cell.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// qrs_div_cell
// one restoring long-division step, one quotient bit per cell
// ---------------------------------------------------------------------------
module qrs_div_cell #(
  parameter int DIV_W  = 50,
  parameter int SIDE_W = 1
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic [DIV_W-1:0]              in_dvd,
  input  logic [qrs_pkg::DEN_W-1:0]     in_den,
  input  logic [qrs_pkg::DEN_W-1:0]     in_rem,
  input  logic [DIV_W-1:0]              in_quo,
  input  logic [SIDE_W-1:0]             in_side,
  output logic                          out_valid,
  output logic [DIV_W-1:0]              out_dvd,
  output logic [qrs_pkg::DEN_W-1:0]     out_den,
  output logic [qrs_pkg::DEN_W-1:0]     out_rem,
  output logic [DIV_W-1:0]              out_quo,
  output logic [SIDE_W-1:0]             out_side
);

  logic [qrs_pkg::DEN_W:0]   rem_sh, diff;
  logic [qrs_pkg::DEN_W-1:0] rem_nxt, rem_r, den_r;
  logic [DIV_W-1:0]          quo_r, dvd_r;
  logic [SIDE_W-1:0]         side_r;
  logic                      valid_r, ge;

  assign rem_sh  = {in_rem, in_dvd[DIV_W-1]};
  assign ge      = rem_sh >= {1'b0, in_den};
  assign diff    = rem_sh - {1'b0, in_den};
  assign rem_nxt = ge ? diff[qrs_pkg::DEN_W-1:0] : rem_sh[qrs_pkg::DEN_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    quo_r  <= {in_quo[DIV_W-2:0], ge};
    dvd_r  <= {in_dvd[DIV_W-2:0], 1'b0};
    den_r  <= in_den;
    side_r <= in_side;
  end

  assign out_valid = valid_r;
  assign out_dvd   = dvd_r;
  assign out_den   = den_r;
  assign out_rem   = rem_r;
  assign out_quo   = quo_r;
  assign out_side  = side_r;

endmodule

### hw/rtl/qrs_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// qrs_back
// quotient signs, second root, clamping and result register
// ---------------------------------------------------------------------------
module qrs_back #(
  parameter int DIV_W = 50
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  qrs_pkg::root_class_t         in_cls,
  input  logic [DIV_W-1:0]             in_q1,
  input  logic                         in_neg1,
  input  logic [DIV_W-1:0]             in_q2,
  input  logic                         in_neg2,
  output logic                         out_valid,
  output logic [1:0]                   out_root_class,
  output logic signed [31:0]           out_root_first,
  output logic signed [31:0]           out_root_second,
  output logic                         out_saturated
);

  localparam int XW = DIV_W + 2;
  localparam logic signed [XW-1:0] MAXV = XW'(32'sh7fffffff);
  localparam logic signed [XW-1:0] MINV = XW'($signed(32'h80000000));

  logic                       v1_r, v2_r, v3_r;
  qrs_pkg::root_class_t       cls1_r, cls2_r;
  logic signed [DIV_W:0]      x1_r, q2_r, x1_nxt, q2_nxt;
  logic signed [XW-1:0]       x1e_r, x2_r, x2_nxt;
  logic [32:0]                c1, c2;
  logic [1:0]                 cls_o_r;
  logic signed [31:0]         r1_r, r2_r, r1_nxt, r2_nxt;
  logic                       sat_r, sat_nxt;

  function automatic logic [32:0] clamp(input logic signed [XW-1:0] v);
    logic [32:0] res;
    if (v > MAXV) begin
      res = {1'b1, 32'h7fffffff};
    end else if (v < MINV) begin
      res = {1'b1, 32'h80000000};
    end else begin
      res = {1'b0, v[31:0]};
    end
    return res;
  endfunction

  assign x1_nxt = in_neg1 ? -$signed({1'b0, in_q1}) : $signed({1'b0, in_q1});
  assign q2_nxt = in_neg2 ? -$signed({1'b0, in_q2}) : $signed({1'b0, in_q2});
  assign x2_nxt = -XW'(x1_r) - XW'(q2_r);

  assign c1 = clamp(x1e_r);
  assign c2 = clamp(x2_r);

  always_comb begin
    r1_nxt  = '0;
    r2_nxt  = '0;
    sat_nxt = 1'b0;
    unique case (cls2_r)
      qrs_pkg::CLS_ONE: begin
        r1_nxt  = c1[31:0];
        sat_nxt = c1[32];
      end
      qrs_pkg::CLS_TWO: begin
        r1_nxt  = c1[31:0];
        r2_nxt  = c2[31:0];
        sat_nxt = c1[32] | c2[32];
      end
      default: begin
        r1_nxt  = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    x1_r    <= x1_nxt;
    q2_r    <= q2_nxt;
    cls1_r  <= in_cls;
    x1e_r   <= XW'(x1_r);
    x2_r    <= x2_nxt;
    cls2_r  <= cls1_r;
    cls_o_r <= cls2_r;
    r1_r    <= r1_nxt;
    r2_r    <= r2_nxt;
    sat_r   <= sat_nxt;
  end

  assign out_valid       = v3_r;
  assign out_root_class  = cls_o_r;
  assign out_root_first  = r1_r;
  assign out_root_second = r2_r;
  assign out_saturated   = sat_r;

endmodule

### hw/rtl/quadratic_root_solver.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// quadratic_root_solver
// real roots of a*x^2 + b*x + c = 0 in signed fixed point
//
//   channel  handshake            payload
//   input    start, busy          in_coef_a, in_coef_b, in_coef_c
//   result   out_valid (strobe)   out_root_class, out_root_first,
//                                 out_root_second, out_saturated
//
// one item per cycle, busy is always low
// the chain holds 3 front stages, 34 square root cells,
// 1 operand stage, 34 + FRAC_BITS division cells, 3 back stages
// reset clears only the valid bits along the chain
// the result strobe lasts one cycle and cannot be held off
// ---------------------------------------------------------------------------
module quadratic_root_solver #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_coef_a,
  input  logic signed [31:0] in_coef_b,
  input  logic signed [31:0] in_coef_c,
  output logic               out_valid,
  output logic [1:0]         out_root_class,
  output logic signed [31:0] out_root_first,
  output logic signed [31:0] out_root_second,
  output logic               out_saturated
);

  localparam int DIV_W  = qrs_pkg::NUM_W + FRAC_BITS;
  localparam int SIDE_W = $bits(qrs_pkg::coef_side_t);
  localparam int NS     = qrs_pkg::SQ_STEPS;

  logic                              sq_v    [0:NS];
  logic [qrs_pkg::RAD_W-1:0]         sq_rad  [0:NS];
  logic [qrs_pkg::SQ_REM_W-1:0]      sq_rem  [0:NS];
  logic [qrs_pkg::ROOT_W-1:0]        sq_root [0:NS];
  logic [SIDE_W-1:0]                 sq_side [0:NS];
  qrs_pkg::coef_side_t               fr_side, md_side;

  logic                              d1_v    [0:DIV_W];
  logic [DIV_W-1:0]                  d1_dvd  [0:DIV_W];
  logic [qrs_pkg::DEN_W-1:0]         d1_den  [0:DIV_W];
  logic [qrs_pkg::DEN_W-1:0]         d1_rem  [0:DIV_W];
  logic [DIV_W-1:0]                  d1_quo  [0:DIV_W];
  logic [2:0]                        d1_side [0:DIV_W];

  logic                              d2_v    [0:DIV_W];
  logic [DIV_W-1:0]                  d2_dvd  [0:DIV_W];
  logic [qrs_pkg::DEN_W-1:0]         d2_den  [0:DIV_W];
  logic [qrs_pkg::DEN_W-1:0]         d2_rem  [0:DIV_W];
  logic [DIV_W-1:0]                  d2_quo  [0:DIV_W];
  logic [0:0]                        d2_side [0:DIV_W];

  logic signed [31:0]                sa, sb, sc;
  logic signed [34:0]                n1, n1m;
  logic signed [33:0]                dn1, dn1m;
  logic [qrs_pkg::NUM_W-1:0]         n1_nxt, n2_nxt, n1_r, n2_r;
  logic [qrs_pkg::DEN_W-1:0]         dn1_nxt, dn2_nxt, dn1_r, dn2_r;
  logic                              neg1_nxt, neg2_nxt, neg1_r, neg2_r, mv_r;
  qrs_pkg::root_class_t              mcls_r;
  logic [31:0]                       bmag, amag;

  assign busy = 1'b0;

  qrs_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (start && !busy),
    .in_a      (in_coef_a),
    .in_b      (in_coef_b),
    .in_c      (in_coef_c),
    .out_valid (sq_v[0]),
    .out_rad   (sq_rad[0]),
    .out_side  (fr_side)
  );

  assign sq_side[0] = fr_side;
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;

  for (genvar i = 0; i < NS; i++) begin : g_sqrt
    qrs_sqrt_cell #(.SIDE_W(SIDE_W)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (sq_v[i]),
      .in_rad    (sq_rad[i]),
      .in_rem    (sq_rem[i]),
      .in_root   (sq_root[i]),
      .in_side   (sq_side[i]),
      .out_valid (sq_v[i+1]),
      .out_rad   (sq_rad[i+1]),
      .out_rem   (sq_rem[i+1]),
      .out_root  (sq_root[i+1]),
      .out_side  (sq_side[i+1])
    );
  end

  // division operands
  assign md_side = sq_side[NS];
  assign sa = md_side.a;
  assign sb = md_side.b;
  assign sc = md_side.c;

  always_comb begin
    if (md_side.cls == qrs_pkg::CLS_TWO) begin
      n1  = $signed({1'b0, sq_root[NS]}) - 35'(sb);
      dn1 = {sa[31], sa, 1'b0};
    end else if (sa == '0) begin
      n1  = -35'(sc);
      dn1 = 34'(sb);
    end else begin
      n1  = -35'(sb);
      dn1 = {sa[31], sa, 1'b0};
    end
    n1m      = n1[34] ? -n1 : n1;
    dn1m     = dn1[33] ? -dn1 : dn1;
    n1_nxt   = n1m[qrs_pkg::NUM_W-1:0];
    dn1_nxt  = dn1m[qrs_pkg::DEN_W-1:0];
    neg1_nxt = n1[34] ^ dn1[33];
    bmag     = sb[31] ? (32'd0 - sb) : sb;
    amag     = sa[31] ? (32'd0 - sa) : sa;
    n2_nxt   = qrs_pkg::NUM_W'(bmag);
    dn2_nxt  = qrs_pkg::DEN_W'(amag);
    neg2_nxt = sb[31] ^ sa[31];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mv_r <= 1'b0;
    end else begin
      mv_r <= sq_v[NS];
    end
  end

  always_ff @(posedge clk) begin
    mcls_r <= md_side.cls;
    n1_r   <= n1_nxt;
    dn1_r  <= dn1_nxt;
    neg1_r <= neg1_nxt;
    n2_r   <= n2_nxt;
    dn2_r  <= dn2_nxt;
    neg2_r <= neg2_nxt;
  end

  assign d1_v[0]    = mv_r;
  assign d1_dvd[0]  = DIV_W'(n1_r) << FRAC_BITS;
  assign d1_den[0]  = dn1_r;
  assign d1_rem[0]  = '0;
  assign d1_quo[0]  = '0;
  assign d1_side[0] = {mcls_r, neg1_r};

  assign d2_v[0]    = mv_r;
  assign d2_dvd[0]  = DIV_W'(n2_r) << FRAC_BITS;
  assign d2_den[0]  = dn2_r;
  assign d2_rem[0]  = '0;
  assign d2_quo[0]  = '0;
  assign d2_side[0] = neg2_r;

  for (genvar i = 0; i < DIV_W; i++) begin : g_div
    qrs_div_cell #(.DIV_W(DIV_W), .SIDE_W(3)) u_first (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (d1_v[i]),
      .in_dvd    (d1_dvd[i]),
      .in_den    (d1_den[i]),
      .in_rem    (d1_rem[i]),
      .in_quo    (d1_quo[i]),
      .in_side   (d1_side[i]),
      .out_valid (d1_v[i+1]),
      .out_dvd   (d1_dvd[i+1]),
      .out_den   (d1_den[i+1]),
      .out_rem   (d1_rem[i+1]),
      .out_quo   (d1_quo[i+1]),
      .out_side  (d1_side[i+1])
    );
    qrs_div_cell #(.DIV_W(DIV_W), .SIDE_W(1)) u_ratio (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (d2_v[i]),
      .in_dvd    (d2_dvd[i]),
      .in_den    (d2_den[i]),
      .in_rem    (d2_rem[i]),
      .in_quo    (d2_quo[i]),
      .in_side   (d2_side[i]),
      .out_valid (d2_v[i+1]),
      .out_dvd   (d2_dvd[i+1]),
      .out_den   (d2_den[i+1]),
      .out_rem   (d2_rem[i+1]),
      .out_quo   (d2_quo[i+1]),
      .out_side  (d2_side[i+1])
    );
  end

  qrs_back #(.DIV_W(DIV_W)) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (d1_v[DIV_W] && d2_v[DIV_W]),
    .in_cls          (qrs_pkg::root_class_t'(d1_side[DIV_W][2:1])),
    .in_q1           (d1_quo[DIV_W]),
    .in_neg1         (d1_side[DIV_W][0]),
    .in_q2           (d2_quo[DIV_W]),
    .in_neg2         (d2_side[DIV_W][0]),
    .out_valid       (out_valid),
    .out_root_class  (out_root_class),
    .out_root_first  (out_root_first),
    .out_root_second (out_root_second),
    .out_saturated   (out_saturated)
  );

endmodule

### hw/rtl/qrs_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// qrs_checker
// port level checks on the quadratic root solver results
// ---------------------------------------------------------------------------
`include "quadratic_root_solver_assert.svh"

module qrs_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic [1:0]  out_root_class,
  input logic [31:0] out_root_first,
  input logic [31:0] out_root_second,
  input logic        out_saturated
);

  logic cls_two, cls_some, cls_empty;

  assign cls_two   = out_root_class == qrs_pkg::CLS_TWO;
  assign cls_some  = (out_root_class == qrs_pkg::CLS_ONE) || cls_two;
  assign cls_empty = !cls_some;

  `QRS_CHECK(a_busy_low, !busy)
  `QRS_IMPLY(a_second_zero, out_valid && !cls_two, out_root_second == 32'd0)
  `QRS_IMPLY(a_sat_class, out_valid && out_saturated, cls_some)
  `QRS_IMPLY(a_no_root_zero, out_valid && cls_empty, (out_root_first == 32'd0) && !out_saturated)

endmodule

bind quadratic_root_solver qrs_checker u_qrs_checker (.*);
